// File: hdl/sync_header_color_frame_receiver_macros.svh
// Assertion helpers used by the checker file.
`ifndef SYNC_HEADER_COLOR_FRAME_RECEIVER_MACROS_SVH
`define SYNC_HEADER_COLOR_FRAME_RECEIVER_MACROS_SVH

// Check prop on every rising clk edge outside reset.
`define SHCFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop on every rising clk edge, reset included.
`define SHCFR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/shcfr_pkg.sv
package shcfr_pkg;

  localparam int unsigned POS_W = 6;
  localparam int unsigned CNT_W = 3;
  localparam int unsigned FRAME_PAYLOAD = 5;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  localparam logic [7:0] CH_ONE = 8'd1;
  localparam logic [7:0] CH_TWO = 8'd2;

  // payload slots in capture order
  localparam logic [CNT_W-1:0] SLOT_CH  = 3'd0;
  localparam logic [CNT_W-1:0] SLOT_RED = 3'd1;
  localparam logic [CNT_W-1:0] SLOT_GRN = 3'd2;
  localparam logic [CNT_W-1:0] SLOT_BLU = 3'd3;
  localparam logic [CNT_W-1:0] SLOT_SUM = 3'd4;

  typedef struct packed {
    logic [1:0] channel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

endpackage

// File: hdl/sync_header_color_frame_receiver.sv
// Color frame receiver: hunts a 0xAA,0x55 sync header in a stream of received
// bytes and returns the channel/red/green/blue frame behind it.
// Input channel: one byte per request (in_rx_byte) with in_burst_end marking
// the last byte before the line goes idle. A chunk ends on a marked byte or on
// the byte that brings the chunk to BUFFER_BYTES bytes.
// Output channel: at most one color per chunk, sent when the five bytes after
// the header arrived, the 8-bit sum of channel, red, green and blue matches
// the checksum byte, and the channel is 1 or 2.
// A color is registered into the output register as the chunk-ending byte is
// taken, or into the skid register while out_* is held. Throughput: one byte
// per cycle while in_stall is low; framing and frame check are combinational.
// Stall: an output register plus one skid register let the block keep taking
// bytes while a color waits; in_stall rises only when both hold a color.
// Reset (rst_n low, synchronous) clears the hunt state and empties the output
// and skid registers; captured payload bytes are kept.
module sync_header_color_frame_receiver #(
  parameter int unsigned BUFFER_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_burst_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_channel,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  localparam int unsigned POS_W = shcfr_pkg::POS_W;
  localparam int unsigned CNT_W = shcfr_pkg::CNT_W;
  localparam logic [POS_W:0] CHUNK_LIMIT = (POS_W+1)'(BUFFER_BYTES);

  logic [POS_W-1:0] chunk_pos_r, chunk_pos_nxt;
  logic             prev_sync_r, prev_sync_nxt;
  logic             hdr_found_r, hdr_found_nxt;
  logic [CNT_W-1:0] pay_cnt_r, pay_cnt_nxt;
  logic [7:0]       store_r [shcfr_pkg::FRAME_PAYLOAD];
  logic [7:0]       store_nxt [shcfr_pkg::FRAME_PAYLOAD];

  logic               out_valid_r, skid_valid_r;
  shcfr_pkg::color_t  out_r, skid_r;
  shcfr_pkg::color_t  res;
  logic               res_valid;
  logic               in_acc;
  logic               out_move;
  logic [POS_W:0]     pos;
  logic [7:0]         sum;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid & ~skid_valid_r;
  assign out_move = ~out_valid_r | ~out_stall;

  always_comb begin
    chunk_pos_nxt = chunk_pos_r;
    prev_sync_nxt = prev_sync_r;
    hdr_found_nxt = hdr_found_r;
    pay_cnt_nxt   = pay_cnt_r;
    store_nxt     = store_r;
    res_valid     = 1'b0;
    pos           = {1'b0, chunk_pos_r} + (POS_W+1)'(1);

    if (in_acc) begin
      if (hdr_found_r) begin
        if (pay_cnt_r < CNT_W'(shcfr_pkg::FRAME_PAYLOAD)) begin
          store_nxt[pay_cnt_r] = in_rx_byte;
          pay_cnt_nxt = pay_cnt_r + CNT_W'(1);
        end
      end else if (prev_sync_r && in_rx_byte == shcfr_pkg::SYNC_SECOND) begin
        hdr_found_nxt = 1'b1;
        pay_cnt_nxt   = '0;
      end
      prev_sync_nxt = (in_rx_byte == shcfr_pkg::SYNC_FIRST);
    end

    sum = store_nxt[shcfr_pkg::SLOT_CH] + store_nxt[shcfr_pkg::SLOT_RED]
        + store_nxt[shcfr_pkg::SLOT_GRN] + store_nxt[shcfr_pkg::SLOT_BLU];

    res.channel = store_nxt[shcfr_pkg::SLOT_CH][1:0];
    res.red     = store_nxt[shcfr_pkg::SLOT_RED];
    res.green   = store_nxt[shcfr_pkg::SLOT_GRN];
    res.blue    = store_nxt[shcfr_pkg::SLOT_BLU];

    if (in_acc) begin
      if (in_burst_end || pos >= CHUNK_LIMIT) begin
        // chunk ends: judge the frame, then drop all hunt state
        res_valid = hdr_found_nxt
                  && pay_cnt_nxt == CNT_W'(shcfr_pkg::FRAME_PAYLOAD)
                  && sum == store_nxt[shcfr_pkg::SLOT_SUM]
                  && (store_nxt[shcfr_pkg::SLOT_CH] == shcfr_pkg::CH_ONE
                      || store_nxt[shcfr_pkg::SLOT_CH] == shcfr_pkg::CH_TWO);
        chunk_pos_nxt = '0;
        prev_sync_nxt = 1'b0;
        hdr_found_nxt = 1'b0;
        pay_cnt_nxt   = '0;
      end else begin
        chunk_pos_nxt = pos[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_pos_r  <= '0;
      prev_sync_r  <= 1'b0;
      hdr_found_r  <= 1'b0;
      pay_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      chunk_pos_r <= chunk_pos_nxt;
      prev_sync_r <= prev_sync_nxt;
      hdr_found_r <= hdr_found_nxt;
      pay_cnt_r   <= pay_cnt_nxt;
      if (out_move) begin
        out_valid_r  <= skid_valid_r | res_valid;
        skid_valid_r <= 1'b0;
      end else if (res_valid) begin
        // output held: park the new color in the skid register
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
    if (out_move) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_r.channel;
  assign out_red     = out_r.red;
  assign out_green   = out_r.green;
  assign out_blue    = out_r.blue;

endmodule

// File: hdl/shcfr_checker.sv
`include "sync_header_color_frame_receiver_macros.svh"

module shcfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_channel,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  `SHCFR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_channel) && $stable(out_red) && $stable(out_green) && $stable(out_blue), "stalled color changed")
  `SHCFR_ASSERT(a_channel, out_valid |-> out_channel == 2'd1 || out_channel == 2'd2, "color on invalid channel")
  `SHCFR_ASSERT(a_stall_full, in_stall |-> out_valid, "input stalled with empty output")
  `SHCFR_ASSERT(a_rose_src, $rose(out_valid) |-> $past(in_valid && !in_stall), "color without a byte taken")
  `SHCFR_ASSERT_RST(a_reset, !rst_n |=> !out_valid && !in_stall, "reset left output busy")

endmodule

bind sync_header_color_frame_receiver shcfr_checker u_shcfr_checker (.*);

// File: tb/sv/sync_header_color_frame_receiver_tb.sv
`timescale 1ns / 100ps

module sync_header_color_frame_receiver_tb;

  localparam int unsigned CHUNK_BYTES = 32;
  localparam int unsigned RANDOM_ITEMS = 1150;

  typedef enum logic [1:0] {ROW_NONE, ROW_COLOR, ROW_PREDICT} row_check_t;

  typedef struct {
    logic [7:0]        data;
    logic              last;
    row_check_t        check;
    shcfr_pkg::color_t col;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_burst_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_channel;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  // mirror of the framing state
  logic [5:0] frame_pos = '0;
  logic       after_sync = 1'b0;
  logic       hdr_seen = 1'b0;
  logic [2:0] cap_count = '0;
  logic [7:0] cap_bytes [shcfr_pkg::FRAME_PAYLOAD] = '{default: 8'h00};

  shcfr_pkg::color_t pending_colors [$];
  logic [7:0] burst_bytes [$];
  int         mismatches = 0;
  bit         send_quiet = 1'b0;
  bit         recv_quiet = 1'b0;
  int         hold_cycles = 0;

  // a header across a chunk cut, header bytes inside a frame, a bad channel,
  // a short frame
  stim_row_t dir_rows [26] = '{
    '{8'hAA, 1'b0, ROW_NONE, '0},
    '{8'h55, 1'b0, ROW_NONE, '0},
    '{8'h02, 1'b0, ROW_NONE, '0},
    '{8'hFF, 1'b0, ROW_NONE, '0},
    '{8'hFF, 1'b0, ROW_NONE, '0},
    '{8'hFF, 1'b0, ROW_NONE, '0},
    '{8'hFF, 1'b1, ROW_COLOR, '{2'd2, 8'hFF, 8'hFF, 8'hFF}},
    '{8'hAA, 1'b1, ROW_NONE, '0},
    '{8'h55, 1'b0, ROW_NONE, '0},
    '{8'hAA, 1'b0, ROW_NONE, '0},
    '{8'h55, 1'b0, ROW_NONE, '0},
    '{8'h01, 1'b0, ROW_NONE, '0},
    '{8'hAA, 1'b0, ROW_NONE, '0},
    '{8'h55, 1'b0, ROW_NONE, '0},
    '{8'h00, 1'b0, ROW_NONE, '0},
    '{8'h00, 1'b1, ROW_PREDICT, '0},
    '{8'hAA, 1'b0, ROW_NONE, '0},
    '{8'h55, 1'b0, ROW_NONE, '0},
    '{8'h00, 1'b0, ROW_NONE, '0},
    '{8'h00, 1'b0, ROW_NONE, '0},
    '{8'h00, 1'b0, ROW_NONE, '0},
    '{8'h00, 1'b0, ROW_NONE, '0},
    '{8'h00, 1'b1, ROW_NONE, '0},
    '{8'hAA, 1'b0, ROW_NONE, '0},
    '{8'h55, 1'b0, ROW_NONE, '0},
    '{8'h01, 1'b1, ROW_NONE, '0}
  };

  sync_header_color_frame_receiver #(
    .BUFFER_BYTES(CHUNK_BYTES)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rx_byte  (in_rx_byte),
    .in_burst_end(in_burst_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_channel (out_channel),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue)
  );

  always #4 clk = ~clk;

  function automatic int draw_wait(input bit quiet);
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 16);
  endfunction

  // advance the hunt by one byte; returns 1 when the chunk closes on a good frame
  function automatic bit frame_hunt_step(input logic [7:0] b, input logic last,
                                         output shcfr_pkg::color_t col);
    logic [6:0] next_pos;
    logic [7:0] sum;
    bit         hit;
    hit = 1'b0;
    col = '0;
    if (hdr_seen) begin
      if (cap_count < shcfr_pkg::FRAME_PAYLOAD) begin
        cap_bytes[cap_count] = b;
        cap_count = cap_count + 3'd1;
      end
    end else if (after_sync && b == shcfr_pkg::SYNC_SECOND) begin
      hdr_seen = 1'b1;
      cap_count = '0;
    end
    after_sync = (b == shcfr_pkg::SYNC_FIRST);
    next_pos = {1'b0, frame_pos} + 7'd1;
    if (last || next_pos >= CHUNK_BYTES) begin
      if (hdr_seen && cap_count == shcfr_pkg::FRAME_PAYLOAD) begin
        sum = cap_bytes[shcfr_pkg::SLOT_CH] + cap_bytes[shcfr_pkg::SLOT_RED]
              + cap_bytes[shcfr_pkg::SLOT_GRN] + cap_bytes[shcfr_pkg::SLOT_BLU];
        if (sum == cap_bytes[shcfr_pkg::SLOT_SUM] &&
            (cap_bytes[shcfr_pkg::SLOT_CH] == shcfr_pkg::CH_ONE ||
             cap_bytes[shcfr_pkg::SLOT_CH] == shcfr_pkg::CH_TWO)) begin
          hit = 1'b1;
          col.channel = cap_bytes[shcfr_pkg::SLOT_CH][1:0];
          col.red = cap_bytes[shcfr_pkg::SLOT_RED];
          col.green = cap_bytes[shcfr_pkg::SLOT_GRN];
          col.blue = cap_bytes[shcfr_pkg::SLOT_BLU];
        end
      end
      frame_pos = '0;
      after_sync = 1'b0;
      hdr_seen = 1'b0;
      cap_count = '0;
    end else begin
      frame_pos = next_pos[5:0];
    end
    return hit;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0: return shcfr_pkg::SYNC_FIRST;
      1: return shcfr_pkg::SYNC_SECOND;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] color_level();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_noise(input int n);
    repeat (n) burst_bytes.push_back(noise_byte());
  endfunction

  function automatic void add_frame();
    logic [7:0] ch;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] sum;
    if ($urandom_range(0, 7) == 0) ch = 8'($urandom_range(0, 255));
    else ch = 8'($urandom_range(1, 2));
    r = color_level();
    g = color_level();
    b = color_level();
    sum = ch + r + g + b;
    // corrupt the checksum now and then
    if ($urandom_range(0, 7) == 0) sum = sum ^ 8'($urandom_range(1, 255));
    burst_bytes.push_back(shcfr_pkg::SYNC_FIRST);
    burst_bytes.push_back(shcfr_pkg::SYNC_SECOND);
    burst_bytes.push_back(ch);
    burst_bytes.push_back(r);
    burst_bytes.push_back(g);
    burst_bytes.push_back(b);
    burst_bytes.push_back(sum);
  endfunction

  // called at a rising edge; returns at the edge that takes the request
  task automatic send_byte(input logic [7:0] b, input logic last,
                           output bit hit, output shcfr_pkg::color_t col);
    int gap;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_burst_end <= last;
    do @(posedge clk); while (in_stall);
    hit = frame_hunt_step(b, last, col);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_colors.size() != 0);
  endtask

  task automatic send_burst(inout int sent);
    logic              close;
    bit                hit;
    shcfr_pkg::color_t col;
    burst_bytes.delete();
    close = 1'b1;
    send_quiet = ($urandom_range(0, 4) == 0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 8));
        add_frame();
        if ($urandom_range(0, 2) == 0) add_noise($urandom_range(1, 6));
        // fill the chunk so that its length closes it
        if ($urandom_range(0, 5) == 0 && burst_bytes.size() < CHUNK_BYTES) begin
          add_noise(CHUNK_BYTES - burst_bytes.size());
          close = 1'b0;
        end
      end
      6: begin
        burst_bytes.push_back(shcfr_pkg::SYNC_FIRST);
        burst_bytes.push_back(shcfr_pkg::SYNC_SECOND);
        add_noise($urandom_range(0, 4));
      end
      7: add_noise($urandom_range(1, 12));
      8: begin
        add_noise($urandom_range(20, 40));
        add_frame();
      end
      default: begin
        add_noise($urandom_range(1, CHUNK_BYTES));
        close = 1'($urandom_range(0, 1));
      end
    endcase
    foreach (burst_bytes[i]) begin
      send_byte(burst_bytes[i], close && (i == burst_bytes.size() - 1), hit, col);
      if (hit) pending_colors.push_back(col);
    end
    sent += burst_bytes.size();
  endtask

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %02h, got %02h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // result side: random stall after every color taken
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if ($urandom_range(0, 19) == 0) recv_quiet = !recv_quiet;
        hold_cycles = draw_wait(recv_quiet);
      end else if (hold_cycles > 0) begin
        hold_cycles--;
      end
      out_stall <= (hold_cycles > 0);
    end
  end

  always @(posedge clk) begin
    shcfr_pkg::color_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_colors.size() == 0) begin
        $display("%0t ns: color with none pending, expected none, got %0d %02h %02h %02h",
                 $time, out_channel, out_red, out_green, out_blue);
        mismatches++;
      end else begin
        want = pending_colors.pop_front();
        check_field("channel", {6'd0, want.channel}, {6'd0, out_channel});
        check_field("red", want.red, out_red);
        check_field("green", want.green, out_green);
        check_field("blue", want.blue, out_blue);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("sync_header_color_frame_receiver_tb NOT OK");
    $finish;
  end

  initial begin
    int                sent;
    bit                paused;
    bit                hit;
    shcfr_pkg::color_t col;
    sent = 0;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].last, hit, col);
      case (dir_rows[i].check)
        ROW_COLOR: pending_colors.push_back(dir_rows[i].col);
        ROW_PREDICT: if (hit) pending_colors.push_back(col);
        default: ;
      endcase
    end
    wait_drain();

    while (sent < RANDOM_ITEMS) begin
      send_burst(sent);
      // hold the sender once until the result side is empty
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        wait_drain();
        paused = 1'b1;
      end
    end
    wait_drain();
    repeat (20) @(posedge clk);

    if (mismatches == 0 && pending_colors.size() == 0) begin
      $display("sync_header_color_frame_receiver_tb OK");
    end else begin
      $display("sync_header_color_frame_receiver_tb NOT OK");
    end
    $finish;
  end

endmodule
